@@ src/ribbon_gradient_hsv_color_unit_defines.svh @@
// Assertion macros shared by the ribbon gradient HSV color unit.
`ifndef RIBBON_GRADIENT_HSV_COLOR_UNIT_DEFINES_SVH
`define RIBBON_GRADIENT_HSV_COLOR_UNIT_DEFINES_SVH

// Implication checked at every clock edge outside reset.
`define RGHSV_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Condition that must never be true outside reset.
`define RGHSV_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

@@ src/rghsv_pkg.sv @@
// Types and constants of the ribbon gradient HSV color unit.
package rghsv_pkg;

  typedef enum logic [1:0] {
    MODE_RAINBOW = 2'd0,
    MODE_NEON    = 2'd1,
    MODE_AMBER   = 2'd2,
    MODE_GREEN   = 2'd3
  } grad_mode_e;

  typedef struct packed {
    logic [31:0] anim_cycle;
    logic [9:0]  segment_index;
    logic [10:0] segment_total;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } out_item_t;

  localparam int unsigned DIV_DW     = 27;
  localparam int unsigned DIV_VW     = 11;
  localparam int unsigned DIV_BPS    = 3;
  localparam int unsigned DIV_STAGES = DIV_DW / DIV_BPS;

  localparam logic [16:0] HUE_FULL   = 17'd92160;
  localparam logic [16:0] HUE_SECTOR = 17'd15360;
  localparam logic [16:0] ONE_Q16    = 17'd65536;

  localparam logic [15:0] FRAC_095 = 16'd62259;
  localparam logic [15:0] FRAC_090 = 16'd58982;
  localparam logic [15:0] FRAC_070 = 16'd45875;
  localparam logic [15:0] FRAC_055 = 16'd36045;
  localparam logic [15:0] FRAC_035 = 16'd22938;
  localparam logic [15:0] FRAC_025 = 16'd16384;

  localparam logic [8:0] NEON_BASE_DEG = 9'd280;
  localparam logic [8:0] AMBER_DEG     = 9'd38;
  localparam logic [8:0] GREEN_DEG     = 9'd142;

  localparam logic [18:0] RECIP_360 = 19'd372827;
  localparam logic [20:0] RECIP_15  = 21'd1118481;

  typedef struct packed {
    grad_mode_e mode;
    logic       head;
    logic [5:0] c60;
    logic [8:0] neon_deg;
  } side_t;

  typedef struct packed {
    logic [DIV_DW-1:0] hue_dvd;
    logic [DIV_DW-1:0] fade_dvd;
    logic [DIV_VW-1:0] divisor;
  } div_in_t;

  typedef struct packed {
    logic [DIV_DW-1:0] hue_quo;
    logic [DIV_DW-1:0] fade_quo;
  } div_out_t;

  typedef struct packed {
    logic [16:0] hue;
    logic [16:0] chroma;
    logic [16:0] val;
  } hsv_t;

endpackage

@@ src/rghsv_prep.sv @@
// Input stages: dividends, nonzero divisor and cycle residues for the hue terms.
module rghsv_prep import rghsv_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  in_item_t   item_i,
  input  grad_mode_e mode_i,
  output logic       valid_o,
  output div_in_t    div_o,
  output side_t      side_o
);

  logic [10:0] total_nz;
  logic [15:0] fade_rate;
  logic [9:0]  byte_sum;
  logic [13:0] s1_d;
  div_in_t     div_d;

  logic        p1_vld_q, p2_vld_q, p3_vld_q;
  div_in_t     p1_div_q, p2_div_q, p3_div_q;
  grad_mode_e  p1_mode_q, p2_mode_q;
  logic        p1_head_q, p2_head_q;
  logic [2:0]  p1_idx3_q, p2_idx3_q;
  logic [13:0] p1_s1_q;
  logic [8:0]  p2_s3_q;
  side_t       p3_side_q;

  logic [9:0]  s2;
  logic [8:0]  s3_d;
  logic [8:0]  c60_w;
  logic [5:0]  c30;
  logic [7:0]  term;
  logic [7:0]  term_mod;
  logic [8:0]  neon_deg;
  side_t       side_d;

  always_comb begin
    total_nz  = (item_i.segment_total == 11'd0) ? 11'd1 : item_i.segment_total;
    fade_rate = (mode_i == MODE_RAINBOW) ? FRAC_055 : FRAC_070;
    div_d.hue_dvd  = {17'b0, item_i.segment_index} * {10'b0, HUE_FULL};
    div_d.fade_dvd = {17'b0, item_i.segment_index} * {11'b0, fade_rate};
    div_d.divisor  = total_nz;
    byte_sum = {2'b0, item_i.anim_cycle[15:8]} + {2'b0, item_i.anim_cycle[23:16]}
             + {2'b0, item_i.anim_cycle[31:24]};
    s1_d = {6'b0, item_i.anim_cycle[7:0]} + {byte_sum, 4'b0};
  end

  always_comb begin
    s2   = {2'b0, p1_s1_q[7:0]} + {p1_s1_q[13:8], 4'b0};
    s3_d = {1'b0, s2[7:0]} + {3'b0, s2[9:8], 4'b0};
  end

  always_comb begin
    priority if (p2_s3_q >= 9'd300) begin
      c60_w = p2_s3_q - 9'd300;
    end else if (p2_s3_q >= 9'd240) begin
      c60_w = p2_s3_q - 9'd240;
    end else if (p2_s3_q >= 9'd180) begin
      c60_w = p2_s3_q - 9'd180;
    end else if (p2_s3_q >= 9'd120) begin
      c60_w = p2_s3_q - 9'd120;
    end else if (p2_s3_q >= 9'd60) begin
      c60_w = p2_s3_q - 9'd60;
    end else begin
      c60_w = p2_s3_q;
    end
    c30      = (c60_w[5:0] >= 6'd30) ? (c60_w[5:0] - 6'd30) : c60_w[5:0];
    term     = {c30, 2'b00} + ({1'b0, p2_idx3_q, 4'b0} - {5'b0, p2_idx3_q});
    term_mod = (term >= 8'd120) ? (term - 8'd120) : term;
    neon_deg = (term_mod < 8'd80) ? ({1'b0, term_mod} + NEON_BASE_DEG)
                                  : ({1'b0, term_mod} - 9'd80);
    side_d.mode     = p2_mode_q;
    side_d.head     = p2_head_q;
    side_d.c60      = c60_w[5:0];
    side_d.neon_deg = neon_deg;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_vld_q <= 1'b0;
      p2_vld_q <= 1'b0;
      p3_vld_q <= 1'b0;
    end else begin
      p1_vld_q <= valid_i;
      p2_vld_q <= p1_vld_q;
      p3_vld_q <= p2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p1_div_q  <= div_d;
    p1_mode_q <= mode_i;
    p1_head_q <= (item_i.segment_index == 10'd0);
    p1_idx3_q <= item_i.segment_index[2:0];
    p1_s1_q   <= s1_d;
    p2_div_q  <= p1_div_q;
    p2_mode_q <= p1_mode_q;
    p2_head_q <= p1_head_q;
    p2_idx3_q <= p1_idx3_q;
    p2_s3_q   <= s3_d;
    p3_div_q  <= p2_div_q;
    p3_side_q <= side_d;
  end

  assign valid_o = p3_vld_q;
  assign div_o   = p3_div_q;
  assign side_o  = p3_side_q;

endmodule

@@ src/rghsv_div.sv @@
// Pipelined restoring divider: two dividends over one shared divisor, three bits a stage.
`include "ribbon_gradient_hsv_color_unit_defines.svh"
module rghsv_div import rghsv_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  input  div_in_t  div_i,
  output logic     valid_o,
  output div_out_t quo_o
);

  localparam int unsigned LANES = 2;

  typedef struct packed {
    logic [DIV_VW-1:0] rem;
    logic [DIV_DW-1:0] acc;
  } lane_t;

  logic [DIV_STAGES-1:0] vld_q;
  lane_t                 lane_q [DIV_STAGES][LANES];
  lane_t                 lane_d [DIV_STAGES][LANES];
  logic [DIV_VW-1:0]     dvs_q  [DIV_STAGES];
  lane_t                 lane_in [LANES];

  function automatic lane_t div_step(input lane_t cur, input logic [DIV_VW-1:0] dvs);
    lane_t           nxt;
    logic [DIV_VW:0] trial;
    nxt = cur;
    for (int b = 0; b < DIV_BPS; b++) begin
      trial   = {nxt.rem, nxt.acc[DIV_DW-1]};
      nxt.acc = {nxt.acc[DIV_DW-2:0], 1'b0};
      if (trial >= {1'b0, dvs}) begin
        trial      = trial - {1'b0, dvs};
        nxt.acc[0] = 1'b1;
      end
      nxt.rem = trial[DIV_VW-1:0];
    end
    return nxt;
  endfunction

  assign lane_in[0] = {{DIV_VW{1'b0}}, div_i.hue_dvd};
  assign lane_in[1] = {{DIV_VW{1'b0}}, div_i.fade_dvd};

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    for (genvar l = 0; l < LANES; l++) begin : g_lane
      if (s == 0) begin : g_first
        assign lane_d[s][l] = div_step(lane_in[l], div_i.divisor);
      end else begin : g_next
        assign lane_d[s][l] = div_step(lane_q[s-1][l], dvs_q[s-1]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[DIV_STAGES-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int s = 0; s < DIV_STAGES; s++) begin
      for (int l = 0; l < LANES; l++) begin
        lane_q[s][l] <= lane_d[s][l];
      end
      if (s == 0) begin
        dvs_q[s] <= div_i.divisor;
      end else begin
        dvs_q[s] <= dvs_q[s-1];
      end
    end
  end

  assign valid_o        = vld_q[DIV_STAGES-1];
  assign quo_o.hue_quo  = lane_q[DIV_STAGES-1][0].acc;
  assign quo_o.fade_quo = lane_q[DIV_STAGES-1][1].acc;

  `RGHSV_ASSERT_NEVER(a_div_zero, valid_i && (div_i.divisor == '0), "zero divisor entered")
  `RGHSV_ASSERT_IMP(a_div_rem, vld_q[DIV_STAGES-1], (lane_q[DIV_STAGES-1][0].rem < dvs_q[DIV_STAGES-1]) && (lane_q[DIV_STAGES-1][1].rem < dvs_q[DIV_STAGES-1]), "remainder not below divisor")

endmodule

@@ src/rghsv_hue.sv @@
// Hue, saturation and value selection per gradient mode, and chroma product.
`include "ribbon_gradient_hsv_color_unit_defines.svh"
module rghsv_hue import rghsv_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  input  div_out_t quo_i,
  input  side_t    side_i,
  output logic     valid_o,
  output hsv_t     hsv_o
);

  function automatic logic [16:0] fade(input logic [DIV_DW-1:0] dec,
                                       input logic [15:0] floor_v);
    logic [DIV_DW-1:0] lim;
    lim = DIV_DW'(ONE_Q16 - {1'b0, floor_v});
    return (dec >= lim) ? {1'b0, floor_v} : (ONE_Q16 - dec[16:0]);
  endfunction

  logic [18:0] x_d;
  logic [37:0] prod360;
  logic [16:0] val_d;
  logic [15:0] sat_d;

  logic        h1_vld_q, h2_vld_q, h3_vld_q;
  logic [18:0] h1_x_q;
  logic [7:0]  h1_frac_q;
  logic [10:0] h1_qest_q;
  logic [16:0] h1_val_q, h2_val_q;
  logic [15:0] h1_sat_q;
  side_t       h1_side_q, h2_side_q;

  logic [18:0] r360;
  logic [8:0]  deg;
  logic [32:0] cprod;
  logic [16:0] h2_hmod_q;
  logic [16:0] h2_chroma_q;

  logic [17:0] rb_sum;
  logic [17:0] rb_mod;
  logic [16:0] hue_d;
  hsv_t        h3_q;

  always_comb begin
    x_d     = quo_i.hue_quo[DIV_DW-1:8];
    prod360 = {19'b0, x_d} * {19'b0, RECIP_360};
    unique case (side_i.mode)
      MODE_RAINBOW: begin
        if (side_i.head) begin
          sat_d = FRAC_070;
          val_d = ONE_Q16;
        end else begin
          sat_d = FRAC_095;
          val_d = fade(quo_i.fade_quo, FRAC_035);
        end
      end
      MODE_NEON: begin
        sat_d = FRAC_090;
        val_d = ONE_Q16;
      end
      MODE_AMBER, MODE_GREEN: begin
        sat_d = FRAC_095;
        val_d = fade(quo_i.fade_quo, FRAC_025);
      end
    endcase
  end

  always_comb begin
    r360  = h1_x_q - ({8'b0, h1_qest_q} * 19'd360);
    deg   = (r360[9:0] >= 10'd360) ? 9'(r360[9:0] - 10'd360) : r360[8:0];
    cprod = {16'b0, h1_val_q} * {17'b0, h1_sat_q};
  end

  always_comb begin
    rb_sum = {1'b0, h2_hmod_q} + {1'b0, h2_side_q.c60, 11'b0}
           - {3'b0, h2_side_q.c60, 9'b0};
    rb_mod = (rb_sum >= {1'b0, HUE_FULL}) ? (rb_sum - {1'b0, HUE_FULL}) : rb_sum;
    unique case (h2_side_q.mode)
      MODE_RAINBOW: hue_d = rb_mod[16:0];
      MODE_NEON:    hue_d = {h2_side_q.neon_deg, 8'b0};
      MODE_AMBER:   hue_d = {AMBER_DEG, 8'b0};
      MODE_GREEN:   hue_d = {GREEN_DEG, 8'b0};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h1_vld_q <= 1'b0;
      h2_vld_q <= 1'b0;
      h3_vld_q <= 1'b0;
    end else begin
      h1_vld_q <= valid_i;
      h2_vld_q <= h1_vld_q;
      h3_vld_q <= h2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    h1_x_q      <= x_d;
    h1_frac_q   <= quo_i.hue_quo[7:0];
    h1_qest_q   <= prod360[37:27];
    h1_val_q    <= val_d;
    h1_sat_q    <= sat_d;
    h1_side_q   <= side_i;
    h2_hmod_q   <= {deg, h1_frac_q};
    h2_chroma_q <= cprod[32:16];
    h2_val_q    <= h1_val_q;
    h2_side_q   <= h1_side_q;
    h3_q.hue    <= hue_d;
    h3_q.chroma <= h2_chroma_q;
    h3_q.val    <= h2_val_q;
  end

  assign valid_o = h3_vld_q;
  assign hsv_o   = h3_q;

  `RGHSV_ASSERT_IMP(a_hue_range, h3_vld_q, (h3_q.hue < HUE_FULL) && (h3_q.chroma <= h3_q.val), "hue or chroma out of range")

endmodule

@@ src/rghsv_rgb.sv @@
// Six-sector HSV to RGB conversion and 8-bit channel scaling.
`include "ribbon_gradient_hsv_color_unit_defines.svh"
module rghsv_rgb import rghsv_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  input  hsv_t      hsv_i,
  output logic      valid_o,
  output out_item_t rgb_o
);

  localparam logic [16:0] SEC1 = HUE_SECTOR;
  localparam logic [16:0] SEC2 = 17'(2 * HUE_SECTOR);
  localparam logic [16:0] SEC3 = 17'(3 * HUE_SECTOR);
  localparam logic [16:0] SEC4 = 17'(4 * HUE_SECTOR);
  localparam logic [16:0] SEC5 = 17'(5 * HUE_SECTOR);

  function automatic logic [7:0] to8(input logic [16:0] q);
    logic [24:0] s;
    s = {q, 8'b0} - {8'b0, q};
    return (s[24:16] > 9'd255) ? 8'hFF : s[23:16];
  endfunction

  logic [2:0]  sector_d;
  logic [16:0] base;
  logic [13:0] f;
  logic [13:0] sel_d;

  logic        r1_vld_q, r2_vld_q, r3_vld_q, r4_vld_q, r5_vld_q;
  logic [2:0]  r1_sec_q, r2_sec_q, r3_sec_q;
  logic [13:0] r1_sel_q;
  logic [16:0] r1_c_q, r2_c_q, r3_c_q;
  logic [16:0] r1_m_q, r2_m_q, r3_m_q;

  logic [30:0] p;
  logic [20:0] r2_y_q, r3_y_q;

  logic [41:0] pm;
  logic [16:0] r3_qe_q;

  logic [20:0] t15;
  logic [20:0] rem;
  logic [16:0] xq;
  logic [16:0] lr, lg, lb;
  logic [16:0] r4_r_q, r4_g_q, r4_b_q;
  out_item_t   r5_q;

  always_comb begin
    priority if (hsv_i.hue >= SEC5) begin
      sector_d = 3'd5;
      base     = SEC5;
    end else if (hsv_i.hue >= SEC4) begin
      sector_d = 3'd4;
      base     = SEC4;
    end else if (hsv_i.hue >= SEC3) begin
      sector_d = 3'd3;
      base     = SEC3;
    end else if (hsv_i.hue >= SEC2) begin
      sector_d = 3'd2;
      base     = SEC2;
    end else if (hsv_i.hue >= SEC1) begin
      sector_d = 3'd1;
      base     = SEC1;
    end else begin
      sector_d = 3'd0;
      base     = '0;
    end
    f     = 14'(hsv_i.hue - base);
    sel_d = sector_d[0] ? (HUE_SECTOR[13:0] - f) : f;
  end

  always_comb begin
    p  = {14'b0, r1_c_q} * {17'b0, r1_sel_q};
    pm = {21'b0, r2_y_q} * {21'b0, RECIP_15};
  end

  always_comb begin
    t15 = {r3_qe_q, 4'b0} - {4'b0, r3_qe_q};
    rem = r3_y_q - t15;
    xq  = (rem >= 21'd15) ? (r3_qe_q + 17'd1) : r3_qe_q;
    lr  = '0;
    lg  = '0;
    lb  = '0;
    unique case (r3_sec_q)
      3'd0: begin
        lr = r3_c_q;
        lg = xq;
      end
      3'd1: begin
        lr = xq;
        lg = r3_c_q;
      end
      3'd2: begin
        lg = r3_c_q;
        lb = xq;
      end
      3'd3: begin
        lg = xq;
        lb = r3_c_q;
      end
      3'd4: begin
        lr = xq;
        lb = r3_c_q;
      end
      default: begin
        lr = r3_c_q;
        lb = xq;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r1_vld_q <= 1'b0;
      r2_vld_q <= 1'b0;
      r3_vld_q <= 1'b0;
      r4_vld_q <= 1'b0;
      r5_vld_q <= 1'b0;
    end else begin
      r1_vld_q <= valid_i;
      r2_vld_q <= r1_vld_q;
      r3_vld_q <= r2_vld_q;
      r4_vld_q <= r3_vld_q;
      r5_vld_q <= r4_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    r1_sec_q   <= sector_d;
    r1_sel_q   <= sel_d;
    r1_c_q     <= hsv_i.chroma;
    r1_m_q     <= hsv_i.val - hsv_i.chroma;
    r2_y_q     <= p[30:10];
    r2_sec_q   <= r1_sec_q;
    r2_c_q     <= r1_c_q;
    r2_m_q     <= r1_m_q;
    r3_y_q     <= r2_y_q;
    r3_qe_q    <= pm[40:24];
    r3_sec_q   <= r2_sec_q;
    r3_c_q     <= r2_c_q;
    r3_m_q     <= r2_m_q;
    r4_r_q     <= lr + r3_m_q;
    r4_g_q     <= lg + r3_m_q;
    r4_b_q     <= lb + r3_m_q;
    r5_q.red   <= to8(r4_r_q);
    r5_q.green <= to8(r4_g_q);
    r5_q.blue  <= to8(r4_b_q);
  end

  assign valid_o = r5_vld_q;
  assign rgb_o   = r5_q;

  `RGHSV_ASSERT_IMP(a_recip_est, r3_vld_q, rem < 21'd30, "reciprocal quotient off by more than one")

endmodule

@@ src/ribbon_gradient_hsv_color_unit.sv @@
// Top level of the ribbon gradient HSV color unit.
//
//  channel  | signals                            | transfer when
//  ---------+------------------------------------+----------------------------
//  input    | start, busy, in_data_i             | start high and busy low
//  result   | out_strobe_o, out_data_o           | out_strobe_o high, one cycle
//  config   | cfg_valid_i, cfg_ready_o, cfg_data_i | cfg_valid_i and cfg_ready_o
//
// One item enters per clock; each result passes through, in order:
// 3 prep stages, 9 divider stages (3 quotient bits each), 3 hue and 5 RGB stages.
// Reset clears all stage valid bits and sets the gradient mode to rainbow.
// busy stays low and the pipeline never stalls; the receiver cannot stall.
module ribbon_gradient_hsv_color_unit import rghsv_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  in_item_t   in_data_i,
  output logic       out_strobe_o,
  output out_item_t  out_data_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_data_i
);

  grad_mode_e mode_q, mode_d;
  logic       in_fire;

  logic       prep_vld;
  div_in_t    prep_div;
  side_t      prep_side;

  logic       div_vld;
  div_out_t   div_quo;
  side_t      side_q [DIV_STAGES];

  logic       hue_vld;
  hsv_t       hue_hsv;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign in_fire     = start && !busy;
  assign mode_d      = (cfg_valid_i && cfg_ready_o) ? grad_mode_e'(cfg_data_i) : mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_RAINBOW;
    end else begin
      mode_q <= mode_d;
    end
  end

  rghsv_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_fire),
    .item_i  (in_data_i),
    .mode_i  (mode_q),
    .valid_o (prep_vld),
    .div_o   (prep_div),
    .side_o  (prep_side)
  );

  rghsv_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (prep_vld),
    .div_i   (prep_div),
    .valid_o (div_vld),
    .quo_o   (div_quo)
  );

  always_ff @(posedge clk_i) begin
    side_q[0] <= prep_side;
    for (int i = 1; i < DIV_STAGES; i++) begin
      side_q[i] <= side_q[i-1];
    end
  end

  rghsv_hue u_hue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (div_vld),
    .quo_i   (div_quo),
    .side_i  (side_q[DIV_STAGES-1]),
    .valid_o (hue_vld),
    .hsv_o   (hue_hsv)
  );

  rghsv_rgb u_rgb (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (hue_vld),
    .hsv_i   (hue_hsv),
    .valid_o (out_strobe_o),
    .rgb_o   (out_data_o)
  );

endmodule
